// File: rtl/mtst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Momentum trailing-stop trader package
// Shared types, register codes and sizes for the trader block.
// ----------------------------------------------------------------------------
package mtst_pkg;

    localparam int SYMBOLS = 256;
    localparam int IDX_W   = $clog2(SYMBOLS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LVL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_LVL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRACTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_REGIME    = 3'd4;

    localparam logic [14:0] ENTRY_LVL_RST     = 15'd16384;
    localparam logic [14:0] EXIT_LVL_RST      = 15'd9830;
    localparam logic [19:0] POS_LIMIT_RST     = 20'd1000;
    localparam logic [15:0] STOP_FRACTION_RST = 16'd1311;

    localparam logic [16:0] FRAC_ONE = 17'h10000;

    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;
    localparam logic URG_MEDIUM  = 1'b0;
    localparam logic URG_HIGH    = 1'b1;

    typedef struct packed {
        logic [7:0]         symbol_index;
        logic [31:0]        price;
        logic signed [15:0] momentum;
        logic signed [31:0] position;
        logic               trending;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  order_symbol;
        logic        order_side;
        logic [31:0] order_quantity;
        logic        order_urgency;
    } t_out_item;

    typedef struct packed {
        logic [14:0] entry_lvl;
        logic [14:0] exit_lvl;
        logic [19:0] pos_limit;
        logic [15:0] stop_fraction;
        logic        use_regime;
    } t_cfg;

    typedef struct packed {
        logic [31:0] peak;
        logic [31:0] trough;
    } t_stop_entry;

    localparam int ENTRY_W = $bits(t_stop_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TRACK,
        S_MUL,
        S_DECIDE
    } t_state;

endpackage
`default_nettype wire

// File: rtl/mtst_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mtst_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/mtst_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the thresholds, position cap, stop distance and regime gate.
// ----------------------------------------------------------------------------
module mtst_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [mtst_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [mtst_pkg::CFG_DATA_W-1:0] i_data,
    output mtst_pkg::t_cfg                      o_cfg
);
    import mtst_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_ENTRY_LVL:     n_cfg.entry_lvl     = i_data[14:0];
                CFG_EXIT_LVL:      n_cfg.exit_lvl      = i_data[14:0];
                CFG_POS_LIMIT:     n_cfg.pos_limit     = i_data[19:0];
                CFG_STOP_FRACTION: n_cfg.stop_fraction = i_data[15:0];
                CFG_USE_REGIME:    n_cfg.use_regime    = i_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_lvl     <= ENTRY_LVL_RST;
            r_cfg.exit_lvl      <= EXIT_LVL_RST;
            r_cfg.pos_limit     <= POS_LIMIT_RST;
            r_cfg.stop_fraction <= STOP_FRACTION_RST;
            r_cfg.use_regime    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: rtl/momentum_trailing_stop_trader_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Momentum trailing-stop trader
// Turns one market signal per transfer into at most one market order, keeping
// a trailing stop per symbol in an on-chip table.
// ----------------------------------------------------------------------------
// Each signal passes in turn through acceptance, a table read, stop
// tracking, a multiply of the extreme price by the stop factor, and
// decision and write-back; the next signal is taken only after that, as the
// stop table takes a single read-modify-write per signal. The decision state
// waits longer only when it has an order while the output register still
// holds an order that is stalled. The table holds peak and trough prices in
// a RAM with a per-symbol active flag in flip-flops that reset clears at
// once, so there is no clearing pass.
module momentum_trailing_stop_trader_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire mtst_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output mtst_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [mtst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mtst_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mtst_pkg::*;

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    t_in_item          r_item;
    logic [IDX_W-1:0]  idx;
    logic [SYMBOLS-1:0] r_valid;
    t_stop_entry       rd_entry;
    t_stop_entry       old_entry;
    logic [31:0]       r_peak;
    logic [31:0]       r_trough;
    logic              r_act;
    logic [48:0]       r_prod;
    t_out_item         r_out;
    logic              r_out_valid;

    logic              in_xfer;
    logic              pos_nz;
    logic              pos_long;
    logic              pos_short;
    logic [31:0]       trk_peak;
    logic [31:0]       trk_trough;
    logic [31:0]       mul_ext;
    logic [16:0]       mul_fac;

    logic signed [16:0] mom_x;
    logic signed [16:0] ent_x;
    logic signed [16:0] ext_x;
    logic signed [32:0] pos_x;
    logic signed [32:0] maxp_x;
    logic signed [32:0] q_buy;
    logic signed [32:0] q_sell;
    logic [48:0]        lhs;
    logic [31:0]        pos_abs;
    logic               gate;
    logic               stop_fire;
    logic               rev_fire;
    logic               buy_en;
    logic               sell_en;
    logic               exit_go;
    logic               has_res;
    logic               go;
    t_out_item          res;
    t_stop_entry        wr_entry;
    logic               new_act;
    logic               mem_we;

    assign o_cfg_ready = 1'b1;

    mtst_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    assign idx = r_item.symbol_index[IDX_W-1:0];

    mtst_ram #(
        .DEPTH (SYMBOLS),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (idx),
        .i_wdata (wr_entry),
        .i_raddr (idx),
        .o_rdata (rd_entry)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid & ~o_in_stall;

    assign pos_nz    = (r_item.position != 32'sd0);
    assign pos_short = r_item.position[31];
    assign pos_long  = pos_nz & ~pos_short;

    // Stop tracking on the entry read from the table.
    always_comb begin
        old_entry  = r_valid[idx] ? rd_entry : '0;
        trk_peak   = old_entry.peak;
        trk_trough = old_entry.trough;
        if (pos_nz) begin
            if (!r_valid[idx]) begin
                trk_peak   = r_item.price;
                trk_trough = r_item.price;
            end else if (pos_long) begin
                if (r_item.price > old_entry.peak) begin
                    trk_peak = r_item.price;
                end
            end else begin
                if (old_entry.trough == 32'd0 || r_item.price < old_entry.trough) begin
                    trk_trough = r_item.price;
                end
            end
        end
    end

    assign mul_ext = pos_long ? r_peak : r_trough;
    assign mul_fac = pos_long ? (FRAC_ONE - {1'b0, cfg.stop_fraction})
                              : (FRAC_ONE + {1'b0, cfg.stop_fraction});

    // Order selection and write-back data.
    always_comb begin
        mom_x   = {r_item.momentum[15], r_item.momentum};
        ent_x   = {2'b00, cfg.entry_lvl};
        ext_x   = {2'b00, cfg.exit_lvl};
        pos_x   = {r_item.position[31], r_item.position};
        maxp_x  = {13'd0, cfg.pos_limit};
        lhs     = {1'b0, r_item.price, 16'h0000};
        pos_abs = pos_short ? (~r_item.position + 32'd1) : r_item.position;
        q_buy   = pos_short ? maxp_x : (maxp_x - pos_x);
        q_sell  = pos_long ? maxp_x : (maxp_x + pos_x);

        gate      = (cfg.use_regime & ~r_item.trending) | (r_item.price == 32'd0);
        stop_fire = pos_nz & (pos_long ? (lhs <= r_prod) : (lhs >= r_prod));
        rev_fire  = (pos_long & (mom_x < -ext_x)) | (pos_short & (mom_x > ext_x));
        buy_en    = (mom_x > ent_x) & (pos_x < maxp_x);
        sell_en   = ~buy_en & (mom_x < -ent_x) & (pos_x > -maxp_x);
        exit_go   = stop_fire | rev_fire;

        res.order_symbol   = r_item.symbol_index;
        res.order_side     = pos_long ? SIDE_SELL : SIDE_BUY;
        res.order_quantity = pos_abs;
        res.order_urgency  = URG_HIGH;
        has_res            = 1'b0;
        wr_entry.peak      = r_peak;
        wr_entry.trough    = r_trough;
        new_act            = r_act;

        if (!gate) begin
            if (exit_go) begin
                has_res = 1'b1;
                new_act = 1'b0;
            end else if (buy_en) begin
                res.order_side     = SIDE_BUY;
                res.order_quantity = q_buy[31:0];
                res.order_urgency  = URG_MEDIUM;
                has_res            = (q_buy != 33'sd0);
                if (has_res && !r_act) begin
                    wr_entry.peak = r_item.price;
                    new_act       = 1'b1;
                end
            end else if (sell_en) begin
                res.order_side     = SIDE_SELL;
                res.order_quantity = q_sell[31:0];
                res.order_urgency  = URG_MEDIUM;
                has_res            = (q_sell != 33'sd0);
                if (has_res && !r_act) begin
                    wr_entry.trough = r_item.price;
                    new_act         = 1'b1;
                end
            end
        end

        go     = (r_state == S_DECIDE) & (~has_res | ~r_out_valid | ~i_out_stall);
        mem_we = go & ~gate & ~exit_go;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_xfer) n_state = S_READ;
            S_READ:   n_state = S_TRACK;
            S_TRACK:  n_state = S_MUL;
            S_MUL:    n_state = S_DECIDE;
            S_DECIDE: if (go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_data;
        end
        if (r_state == S_TRACK) begin
            r_peak   <= trk_peak;
            r_trough <= trk_trough;
            r_act    <= r_valid[idx] | pos_nz;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_ext * mul_fac;
        end
        if (go && has_res) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (go && !gate) begin
                r_valid[idx] <= new_act;
            end
            if (go && has_res) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_qty_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.order_quantity != 32'd0))
        else $error("order with zero quantity");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_READ))
        else $error("accepted transfer did not start a table read");

    a_valid_in_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_valid != $past(r_valid))) |-> ($past(r_state) == S_DECIDE))
        else $error("stop table flags changed outside write-back");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Momentum trailing-stop trader testbench
// Sends market signals through the trader and compares every order it issues
// with a behavioral copy of the trading rules and the per-symbol stop table
// kept inside the bench. The run covers directed corner cases, then random
// trading episodes under several register settings and flow-control mixes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mtst_pkg::*;

    localparam int DRAIN_CYCLES = 12;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out_item             o_out_data;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int live_signals  = 0;

    t_out_item order_q[$];

    bit        trail_on[SYMBOLS];
    bit [31:0] trail_peak[SYMBOLS];
    bit [31:0] trail_trough[SYMBOLS];

    logic [14:0] entry_thr = ENTRY_LVL_RST;
    logic [14:0] exit_thr  = EXIT_LVL_RST;
    logic [19:0] pos_cap   = POS_LIMIT_RST;
    logic [15:0] stop_frac = STOP_FRACTION_RST;
    logic        regime_on = 1'b0;

    momentum_trailing_stop_trader_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_orders
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (order_q.size() == 0) begin
                $error("unexpected order for symbol %0d", o_out_data.order_symbol);
                fail_count++;
            end else begin
                want = order_q.pop_front();
                if (o_out_data.order_symbol !== want.order_symbol) begin
                    $error("order_symbol: expected %0d, got %0d",
                           want.order_symbol, o_out_data.order_symbol);
                    fail_count++;
                end
                if (o_out_data.order_side !== want.order_side) begin
                    $error("order_side: expected %0d, got %0d",
                           want.order_side, o_out_data.order_side);
                    fail_count++;
                end
                if (o_out_data.order_quantity !== want.order_quantity) begin
                    $error("order_quantity: expected %0d, got %0d",
                           want.order_quantity, o_out_data.order_quantity);
                    fail_count++;
                end
                if (o_out_data.order_urgency !== want.order_urgency) begin
                    $error("order_urgency: expected %0d, got %0d",
                           want.order_urgency, o_out_data.order_urgency);
                    fail_count++;
                end
            end
        end
    end

    function automatic void clear_trail(input int unsigned slot);
        trail_on[slot]     = 1'b0;
        trail_peak[slot]   = '0;
        trail_trough[slot] = '0;
    endfunction

    function automatic bit predict_order(input t_in_item sig, output t_out_item ord);
        int unsigned slot;
        longint      pos;
        longint      cap;
        longint      qty;
        int          mom;
        int          ent;
        int          ext;
        bit [63:0]   lhs;
        bit [63:0]   rhs;
        bit          fired;
        slot = sig.symbol_index % SYMBOLS;
        pos  = longint'(sig.position);
        mom  = int'(sig.momentum);
        cap  = longint'(pos_cap);
        ent  = int'(entry_thr);
        ext  = int'(exit_thr);
        ord  = '0;
        ord.order_symbol = sig.symbol_index;
        if (regime_on && !sig.trending) return 1'b0;
        if (sig.price == 0) return 1'b0;
        if (pos != 0) begin
            if (!trail_on[slot]) begin
                trail_on[slot]     = 1'b1;
                trail_peak[slot]   = sig.price;
                trail_trough[slot] = sig.price;
            end else if (pos > 0) begin
                if (sig.price > trail_peak[slot]) trail_peak[slot] = sig.price;
            end else if (trail_trough[slot] == 0 || sig.price < trail_trough[slot]) begin
                trail_trough[slot] = sig.price;
            end
            lhs = {16'd0, sig.price, 16'd0};
            if (pos > 0) begin
                rhs   = 64'(trail_peak[slot]) * (64'(FRAC_ONE) - 64'(stop_frac));
                fired = (lhs <= rhs);
            end else begin
                rhs   = 64'(trail_trough[slot]) * (64'(FRAC_ONE) + 64'(stop_frac));
                fired = (lhs >= rhs);
            end
            if (fired) begin
                qty = (pos > 0) ? pos : -pos;
                ord.order_side     = (pos > 0) ? SIDE_SELL : SIDE_BUY;
                ord.order_quantity = qty[31:0];
                ord.order_urgency  = URG_HIGH;
                clear_trail(slot);
                return 1'b1;
            end
        end
        if (pos > 0 && mom < -ext) begin
            ord.order_side     = SIDE_SELL;
            ord.order_quantity = pos[31:0];
            ord.order_urgency  = URG_HIGH;
            clear_trail(slot);
            return 1'b1;
        end
        if (pos < 0 && mom > ext) begin
            qty = -pos;
            ord.order_side     = SIDE_BUY;
            ord.order_quantity = qty[31:0];
            ord.order_urgency  = URG_HIGH;
            clear_trail(slot);
            return 1'b1;
        end
        if (mom > ent && pos < cap) begin
            qty = cap - pos;
            if (qty > cap) qty = cap;
            if (qty > 0) begin
                ord.order_side     = SIDE_BUY;
                ord.order_quantity = qty[31:0];
                ord.order_urgency  = URG_MEDIUM;
                if (!trail_on[slot]) begin
                    trail_peak[slot] = sig.price;
                    trail_on[slot]   = 1'b1;
                end
                return 1'b1;
            end
        end else if (mom < -ent && pos > -cap) begin
            qty = cap + pos;
            if (qty > cap) qty = cap;
            if (qty > 0) begin
                ord.order_side     = SIDE_SELL;
                ord.order_quantity = qty[31:0];
                ord.order_urgency  = URG_MEDIUM;
                if (!trail_on[slot]) begin
                    trail_trough[slot] = sig.price;
                    trail_on[slot]     = 1'b1;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic send_signal(input t_in_item sig);
        t_out_item ord;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= sig;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (!(regime_on && !sig.trending) && sig.price != 0) live_signals++;
        if (predict_order(sig, ord)) order_q = {order_q, ord};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (order_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ENTRY_LVL:     entry_thr = val[14:0];
            CFG_EXIT_LVL:      exit_thr  = val[14:0];
            CFG_POS_LIMIT:     pos_cap   = val[19:0];
            CFG_STOP_FRACTION: stop_frac = val[15:0];
            CFG_USE_REGIME:    regime_on = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int ent, input int ext, input int cap,
                                  input int frac, input int regime);
        wait_drained();
        write_reg(CFG_ENTRY_LVL, CFG_DATA_W'(ent));
        write_reg(CFG_EXIT_LVL, CFG_DATA_W'(ext));
        write_reg(CFG_POS_LIMIT, CFG_DATA_W'(cap));
        write_reg(CFG_STOP_FRACTION, CFG_DATA_W'(frac));
        write_reg(CFG_USE_REGIME, CFG_DATA_W'(regime));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_signal(input logic [7:0] sym, input logic [31:0] px,
                                   input int mom, input longint pos, input bit trend);
        t_in_item sig;
        sig.symbol_index = sym;
        sig.price        = px;
        sig.momentum     = 16'(mom);
        sig.position     = 32'(pos);
        sig.trending     = trend;
        send_signal(sig);
    endtask

    // Most traffic is short episodes on a few symbols: usually an entry, then a
    // held position with a price walk that may trip the stop or reverse.
    task automatic run_random(input int count, input int sym_span);
        t_in_item    sig;
        int          goal;
        int          steps;
        int          m;
        int          ent;
        int          ext;
        bit          go_long;
        bit          fresh;
        longint      mag;
        longint      px;
        longint      stride;
        logic [7:0]  sym;
        goal = live_signals + count;
        while (live_signals < goal) begin
            if ($urandom_range(99) < 25) begin
                sig.symbol_index = 8'($urandom());
                sig.price        = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom());
                sig.momentum     = 16'($urandom());
                sig.position     = 32'($urandom());
                sig.trending     = 1'($urandom_range(1));
                send_signal(sig);
            end else begin
                ent     = int'(entry_thr);
                ext     = int'(exit_thr);
                sym     = 8'($urandom_range(sym_span - 1));
                px      = ($urandom_range(3) == 0) ? longint'($urandom())
                                                   : longint'($urandom_range(200000, 100));
                if (px == 0) px = 1;
                stride  = px / 40 + 1;
                go_long = 1'($urandom_range(1));
                fresh   = ($urandom_range(9) < 7);
                mag     = ($urandom_range(4) == 0) ? longint'($urandom_range(32'h7FFF_FFFF, 1))
                                                   : longint'($urandom_range(2 * pos_cap + 2, 1));
                steps   = $urandom_range(8, 2);
                for (int k = 0; k < steps; k++) begin
                    case ($urandom_range(5))
                        0: m = $signed(16'($urandom()));
                        1: m = go_long ? -(ext + 1 + int'($urandom_range(200)))
                                       : (ext + 1 + int'($urandom_range(200)));
                        default: m = int'($urandom_range(2 * ext)) - ext;
                    endcase
                    if (k == 0 && fresh) begin
                        m = go_long ? (ent + 1 + int'($urandom_range(300)))
                                    : -(ent + 1 + int'($urandom_range(300)));
                    end
                    if (m > 32767) m = 32767;
                    if (m < -32768) m = -32768;
                    sig.symbol_index = sym;
                    sig.price        = px[31:0];
                    sig.momentum     = 16'(m);
                    sig.position     = (k == 0 && fresh) ? 32'd0
                                     : (go_long ? 32'(mag) : 32'(-mag));
                    sig.trending     = regime_on ? ($urandom_range(99) < 85)
                                                 : 1'($urandom_range(1));
                    send_signal(sig);
                    px = px + longint'($urandom_range(2 * stride)) - stride;
                    if (px < 1) px = 1;
                    if (px > 64'hFFFF_FFFF) px = 64'hFFFF_FFFF;
                end
            end
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 29;
        stall_pct     = 57;
        directed_signal(8'd0, 32'd0, 32767, 0, 1'b1);
        directed_signal(8'd0, 32'd1000, 32767, 0, 1'b1);
        directed_signal(8'd0, 32'd1100, 0, 1000, 1'b1);
        directed_signal(8'd0, 32'd1070, 0, 1000, 1'b1);
        directed_signal(8'd1, 32'd5000, -32768, 0, 1'b1);
        directed_signal(8'd1, 32'd4900, 0, -1000, 1'b1);
        directed_signal(8'd1, 32'd4900, 9831, -1000, 1'b1);
        directed_signal(8'd2, 32'd200, -9831, 500, 1'b0);
        directed_signal(8'd3, 32'hFFFF_FFFF, 32767, 2147483647, 1'b1);
        directed_signal(8'd3, 32'hFFFF_FFFF, 32767, -2147483647 - 1, 1'b1);
        directed_signal(8'd255, 32'd7, 16385, -5, 1'b1);
        directed_signal(8'd255, 32'd7, 16384, 0, 1'b1);
        directed_signal(8'd5, 32'd100, 16385, 999, 1'b1);
        directed_signal(8'd5, 32'd100, 16385, 1000, 1'b1);
        directed_signal(8'd6, 32'd100, -16385, -999, 1'b1);
        directed_signal(8'd6, 32'd103, 0, -999, 1'b1);
        directed_signal(8'd8, 32'd1, -32768, 1, 1'b0);
        directed_signal(8'd9, 32'h8000_0000, -9830, 2147483647, 1'b1);
        directed_signal(8'd9, 32'h7000_0000, 0, 1, 1'b1);
        directed_signal(8'd10, 32'h5555_5555, -16385, -1000, 1'b1);
        directed_signal(8'd10, 32'hAAAA_AAAA, 0, 0, 1'b1);
        directed_signal(8'd85, 32'hAAAA_AAAA, 16385, -1, 1'b1);
        directed_signal(8'd170, 32'h5555_5555, -16385, 0, 1'b0);
    endtask

    task automatic test_default_trading();
        run_random(150, 8);
    endtask

    task automatic test_loose_limits();
        apply_settings(0, 0, 1048575, 0, 0);
        send_idle_pct = 57;
        stall_pct     = 29;
        run_random(100, 16);
    endtask

    task automatic test_strict_limits();
        apply_settings(32767, 32767, 0, 65535, 1);
        run_random(60, 8);
    endtask

    task automatic test_regime_gating();
        apply_settings(8000, 4000, 50000, 3000, 1);
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(120, 32);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_default_trading();
        test_loose_limits();
        test_strict_limits();
        test_regime_gating();
        wait_drained();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
